// File: hw/rtl/tup_pkg.sv
package tup_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM) + 1;
  localparam int unsigned CNT_W   = $clog2(MAX_DIM);
  localparam int unsigned PADDR_W = 5;

  // pixel format codes
  localparam logic [2:0] FMT_ALPHA = 3'd0;
  localparam logic [2:0] FMT_LUM   = 3'd1;
  localparam logic [2:0] FMT_LUMA  = 3'd2;
  localparam logic [2:0] FMT_RGB   = 3'd3;
  localparam logic [2:0] FMT_RGBA  = 3'd4;

  // pixel type codes
  localparam logic [1:0] TYP_UBYTE = 2'd0;
  localparam logic [1:0] TYP_565   = 2'd1;
  localparam logic [1:0] TYP_4444  = 2'd2;
  localparam logic [1:0] TYP_5551  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_FORMAT = 3'd0;
  localparam logic [2:0] REG_TYPE   = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_COUNT  = 3'd3;
  localparam logic [2:0] REG_ALIGN  = 3'd4;

  typedef struct packed {
    logic [2:0]       pixel_format;
    logic [1:0]       pixel_type;
    logic [DIM_W-1:0] row_width;
    logic [DIM_W-1:0] row_count;
    logic [3:0]       row_align;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       last_pixel;
    logic       format_error;
  } pix_t;

  // source bytes per pixel, zero for an unsupported pair
  function automatic logic [2:0] bytes_per_pixel(logic [2:0] fmt, logic [1:0] typ);
    logic [2:0] n;
    n = 3'd0;
    if (typ == TYP_UBYTE) begin
      case (fmt)
        FMT_ALPHA, FMT_LUM: n = 3'd1;
        FMT_LUMA:           n = 3'd2;
        FMT_RGB:            n = 3'd3;
        FMT_RGBA:           n = 3'd4;
        default:            n = 3'd0;
      endcase
    end else if (typ == TYP_565 && fmt == FMT_RGB) begin
      n = 3'd2;
    end else if ((typ == TYP_4444 || typ == TYP_5551) && fmt == FMT_RGBA) begin
      n = 3'd2;
    end
    return n;
  endfunction

  // rounded widening to 8 bits, (v*255 + max/2) / max
  // 4 bits: v*17 exactly, so replication is the rounded value
  function automatic logic [7:0] widen4(logic [3:0] v);
    return {v, v};
  endfunction

  // divide by 31 as a reciprocal multiply, exact over the whole field range
  function automatic logic [7:0] widen5(logic [4:0] v);
    logic [12:0] x;
    logic [26:0] p;
    x = 13'(v) * 13'd255 + 13'd15;
    p = 27'(x) * 27'd8457;
    return p[25:18];
  endfunction

  // divide by 63 as a reciprocal multiply, exact over the whole field range
  function automatic logic [7:0] widen6(logic [5:0] v);
    logic [13:0] x;
    logic [28:0] p;
    x = 14'(v) * 14'd255 + 14'd31;
    p = 29'(x) * 29'd16645;
    return p[27:20];
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage

// File: hw/rtl/tup_apb_regs.sv
module tup_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tup_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output tup_pkg::cfg_t              cfg_o,
  output logic                       clear_o
);
  import tup_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic       clear_d;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d   = cfg_q;
    clear_d = 1'b0;
    if (wr_en) begin
      unique case (idx)
        REG_FORMAT: begin
          cfg_d.pixel_format = pwdata[2:0];
          clear_d = 1'b1;
        end
        REG_TYPE: begin
          cfg_d.pixel_type = pwdata[1:0];
          clear_d = 1'b1;
        end
        REG_WIDTH: begin
          cfg_d.row_width = pwdata[DIM_W-1:0];
          clear_d = 1'b1;
        end
        REG_COUNT: begin
          cfg_d.row_count = pwdata[DIM_W-1:0];
          clear_d = 1'b1;
        end
        REG_ALIGN: begin
          cfg_d.row_align = pwdata[3:0];
          clear_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format <= FMT_RGB;
      cfg_q.pixel_type   <= TYP_UBYTE;
      cfg_q.row_width    <= DIM_W'(1);
      cfg_q.row_count    <= DIM_W'(1);
      cfg_q.row_align    <= 4'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_FORMAT: prdata = 32'(cfg_q.pixel_format);
      REG_TYPE:   prdata = 32'(cfg_q.pixel_type);
      REG_WIDTH:  prdata = 32'(cfg_q.row_width);
      REG_COUNT:  prdata = 32'(cfg_q.row_count);
      REG_ALIGN:  prdata = 32'(cfg_q.row_align);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o   = cfg_q;
  assign clear_o = clear_d;

endmodule

// File: hw/rtl/tup_core.sv
module tup_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tup_pkg::cfg_t cfg_i,
  input  logic          clear_i,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  output logic          has_result_o,
  output tup_pkg::pix_t pix_o
);
  import tup_pkg::*;

  logic [1:0]       byte_slot_q, byte_slot_d;
  logic [23:0]      held_bytes_q, held_bytes_d;
  logic [CNT_W-1:0] column_count_q, column_count_d;
  logic [CNT_W-1:0] row_index_q, row_index_d;
  logic [2:0]       row_byte_phase_q, row_byte_phase_d;
  logic [2:0]       pad_left_q, pad_left_d;

  logic [2:0]       bpp;
  logic [3:0]       align;
  logic [DIM_W-1:0] rw_eff, rc_eff;
  logic             err, padding, complete, row_done, img_done;
  logic [3:0]       phase_inc;
  logic [2:0]       phase_nx;
  logic [3:0]       pad_full;
  logic [7:0]       b0, b1, b2;
  logic [15:0]      word;
  logic [7:0]       red, green, blue;

  assign bpp    = bytes_per_pixel(cfg_i.pixel_format, cfg_i.pixel_type);
  assign rw_eff = clamp_dim(cfg_i.row_width);
  assign rc_eff = clamp_dim(cfg_i.row_count);

  always_comb begin
    align = cfg_i.row_align;
    if (align == 4'd0) align = 4'd1;
    else if (align > 4'd8) align = 4'd8;
  end

  assign err       = (bpp == 3'd0);
  assign padding   = (pad_left_q != 3'd0);
  assign phase_inc = {1'b0, row_byte_phase_q} + 4'd1;
  assign phase_nx  = (phase_inc == align) ? 3'd0 : phase_inc[2:0];
  assign pad_full  = (phase_nx != 3'd0) ? (align - {1'b0, phase_nx}) : 4'd0;
  assign complete  = ({1'b0, byte_slot_q} + 3'd1) >= bpp;
  assign row_done  = ({1'b0, column_count_q} + DIM_W'(1)) >= rw_eff;
  assign img_done  = ({1'b0, row_index_q} + DIM_W'(1)) >= rc_eff;

  // the byte now arriving fills its own slot; a fourth byte (alpha) is dropped
  assign b0   = (byte_slot_q == 2'd0) ? byte_i : held_bytes_q[7:0];
  assign b1   = (byte_slot_q == 2'd1) ? byte_i : held_bytes_q[15:8];
  assign b2   = (byte_slot_q == 2'd2) ? byte_i : held_bytes_q[23:16];
  assign word = {b1, b0};

  always_comb begin
    red   = b0;
    green = b0;
    blue  = b0;
    case (cfg_i.pixel_type)
      TYP_UBYTE: begin
        if (cfg_i.pixel_format >= FMT_RGB) begin
          green = b1;
          blue  = b2;
        end
      end
      TYP_565: begin
        red   = widen5(word[15:11]);
        green = widen6(word[10:5]);
        blue  = widen5(word[4:0]);
      end
      TYP_4444: begin
        red   = widen4(word[15:12]);
        green = widen4(word[11:8]);
        blue  = widen4(word[7:4]);
      end
      default: begin
        red   = widen5(word[15:11]);
        green = widen5(word[10:6]);
        blue  = widen5(word[5:1]);
      end
    endcase
  end

  assign has_result_o = err || (!padding && complete);

  always_comb begin
    pix_o = '0;
    if (err) begin
      pix_o.format_error = 1'b1;
    end else begin
      pix_o.red        = red;
      pix_o.green      = green;
      pix_o.blue       = blue;
      pix_o.row_end    = row_done;
      pix_o.last_pixel = row_done && img_done;
    end
  end

  always_comb begin
    byte_slot_d      = byte_slot_q;
    held_bytes_d     = held_bytes_q;
    column_count_d   = column_count_q;
    row_index_d      = row_index_q;
    row_byte_phase_d = row_byte_phase_q;
    pad_left_d       = pad_left_q;
    if (clear_i) begin
      byte_slot_d      = '0;
      held_bytes_d     = '0;
      column_count_d   = '0;
      row_index_d      = '0;
      row_byte_phase_d = '0;
      pad_left_d       = '0;
    end else if (step_i && !err) begin
      if (padding) begin
        pad_left_d = pad_left_q - 3'd1;
      end else begin
        row_byte_phase_d = phase_nx;
        if (!complete) begin
          case (byte_slot_q)
            2'd0:    held_bytes_d[7:0]   = byte_i;
            2'd1:    held_bytes_d[15:8]  = byte_i;
            2'd2:    held_bytes_d[23:16] = byte_i;
            default: ;
          endcase
          byte_slot_d = byte_slot_q + 2'd1;
        end else begin
          byte_slot_d  = '0;
          held_bytes_d = '0;
          if (row_done) begin
            column_count_d   = '0;
            row_byte_phase_d = '0;
            if (img_done) begin
              row_index_d = '0;
              pad_left_d  = '0;
            end else begin
              row_index_d = row_index_q + CNT_W'(1);
              pad_left_d  = pad_full[2:0];
            end
          end else begin
            column_count_d = column_count_q + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_slot_q      <= '0;
      held_bytes_q     <= '0;
      column_count_q   <= '0;
      row_index_q      <= '0;
      row_byte_phase_q <= '0;
      pad_left_q       <= '0;
    end else begin
      byte_slot_q      <= byte_slot_d;
      held_bytes_q     <= held_bytes_d;
      column_count_q   <= column_count_d;
      row_index_q      <= row_index_d;
      row_byte_phase_q <= row_byte_phase_d;
      pad_left_q       <= pad_left_d;
    end
  end

`ifndef SYNTHESIS
  // row padding is only ever skipped between whole pixels
  a_pad_on_pixel_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_left_q != 3'd0 |-> byte_slot_q == 2'd0)
    else $error("padding pending with a part-gathered pixel");

  a_column_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, column_count_q} < rw_eff)
    else $error("column position beyond row width");

  a_row_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, row_index_q} < rc_eff)
    else $error("row position beyond row count");

  a_phase_in_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, row_byte_phase_q} < align)
    else $error("row byte phase not below alignment");
`endif

endmodule

// File: hw/rtl/texel_unpack_to_rgb888_top.sv
// Byte-stream texel unpacker: takes one source byte per transaction and gives one RGB888
// pixel per completed source pixel, with row_end and last_pixel marking row and image ends.
// A byte enters in every cycle for a sustained rate of one byte per clock unless a pixel
// waits on out_ready_i; a pixel leaves via input register, then result register. Bytes that
// only fill a pixel, and row pad bytes, are taken and give no transaction on the output.
// An unsupported format/type pair returns one error transaction per byte. Any register write
// restarts the image, so program the registers only while the block is idle.
module texel_unpack_to_rgb888_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tup_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  src_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  red_o,
  output logic [7:0]                  green_o,
  output logic [7:0]                  blue_o,
  output logic                        row_end_o,
  output logic                        last_pixel_o,
  output logic                        format_error_o
);
  import tup_pkg::*;

  cfg_t       cfg;
  logic       clear;
  logic       has_result;
  pix_t       pix;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  pix_t       out_q;
  logic       advance;

  tup_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .clear_o (clear)
  );

  tup_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .clear_i      (clear),
    .step_i       (advance),
    .byte_i       (in_byte_q),
    .has_result_o (has_result),
    .pix_o        (pix)
  );

  // a held byte moves on unless it makes a pixel and the result register is stuck
  assign advance    = in_valid_q && (!has_result || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_valid_d = in_ready_o ? in_valid_i : in_valid_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && has_result) out_valid_d = 1'b1;
    else if (out_ready_i)      out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_byte_q <= src_byte_i;
    if (advance && has_result)    out_q     <= pix;
  end

  assign out_valid_o    = out_valid_q;
  assign red_o          = out_q.red;
  assign green_o        = out_q.green;
  assign blue_o         = out_q.blue;
  assign row_end_o      = out_q.row_end;
  assign last_pixel_o   = out_q.last_pixel;
  assign format_error_o = out_q.format_error;

endmodule
